// ===== src/jets_pkg.sv =====
// Package for the Julia escape-time shader: field widths, register codes,
// reset values, parameter defaults and the sequencer state type.
// Depends on nothing; used by julia_escape_time_shader.
package jets_pkg;

    // Field widths
    localparam int POS_W      = 12;
    localparam int SHADE_W    = 8;
    localparam int SIZE_W     = 13;
    localparam int C_W        = 30;
    localparam int ITER_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    // Coordinate numerator 2*S - 4*pos: signed width and magnitude width
    localparam int NUM_W = 15;
    localparam int MAG_W = 14;

    // Shade scaling and the width of 255*k
    localparam int SHADE_SCALE = 255;
    localparam int SPROD_W     = 24;

    // Parameter defaults
    localparam int MAX_IMAGE_SIZE_DEF = 4096;
    localparam int FRAC_BITS_DEF      = 28;

    // Register reset values
    localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE = 13'd2500;
    localparam logic [ITER_W-1:0] RST_MAX_ITER   = 16'd83;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_SIZE = 2'd0,
        REG_C_RE       = 2'd1,
        REG_C_IM       = 2'd2,
        REG_MAX_ITER   = 2'd3
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_COL,
        ST_WAIT_COL,
        ST_DIV_ROW,
        ST_WAIT_ROW,
        ST_SQX,
        ST_SQY,
        ST_CROSS,
        ST_UPD,
        ST_SHADE_DIV,
        ST_SHADE_WAIT,
        ST_EMIT
    } t_state;

endpackage

// ===== src/jets_div.sv =====
// Restoring divider for the shader, one quotient bit per cycle.
// Unsigned dividend of DW bits over a divisor of VW bits; no package needed.
module jets_div #(
    parameter int DW = 42,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_dvd, n_dvd;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_dvs, n_dvs;

    logic [VW:0] shifted;
    logic [VW:0] trial;
    logic        fits;

    // Shift in one dividend bit, subtract when the divisor fits
    always_comb begin
        shifted = {r_rem, r_dvd[DW-1]};
        trial   = shifted - {1'b0, r_dvs};
        fits    = shifted >= {1'b0, r_dvs};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dvs  = r_dvs;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DW);
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DW-2:0], fits};
            n_rem = fits ? trial[VW-1:0] : shifted[VW-1:0];
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers reset, operands do not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

// ===== src/julia_escape_time_shader.sv =====
// Julia escape-time shader: one pixel in, one shaded pixel out.
// Each pixel runs two coordinate divisions, then the iteration step through
// ST_SQX, ST_SQY, ST_CROSS and ST_UPD around one multiplier, then the shade
// division, skipped when no iteration runs; all share the bit-serial divider.
// A new pixel is taken only after the last one went to the output register,
// which waits while the output stalls. Reset: synchronous active low; control
// and configuration registers return to defaults, last shade 0.
module julia_escape_time_shader #(
    parameter int MAX_IMAGE_SIZE = jets_pkg::MAX_IMAGE_SIZE_DEF,
    parameter int FRAC_BITS      = jets_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [jets_pkg::POS_W-1:0]      i_pixel_col,
    input  logic [jets_pkg::POS_W-1:0]      i_pixel_row,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [jets_pkg::POS_W-1:0]      o_out_col,
    output logic [jets_pkg::POS_W-1:0]      o_out_row,
    output logic [jets_pkg::SHADE_W-1:0]    o_shade,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [jets_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jets_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QW = FRAC_BITS + 4;
    localparam int MW = 2 * QW;
    localparam int DW = FRAC_BITS + jets_pkg::MAG_W;
    localparam int UW = ((FRAC_BITS + 11 > 31) ? FRAC_BITS + 11 : 31) + 1;
    localparam int SW = jets_pkg::SIZE_W;
    localparam int IW = jets_pkg::ITER_W;

    // Escape bound 4.0 at product scale
    localparam logic [MW:0] FOUR = {{(MW - 2 * FRAC_BITS - 2){1'b0}}, 1'b1,
                                    {(2 * FRAC_BITS + 2){1'b0}}};
    // Q4 limits at update width and at quotient width
    localparam logic signed [UW-1:0] QHI_U = {{(UW - QW + 1){1'b0}}, {(QW - 1){1'b1}}};
    localparam logic signed [UW-1:0] QLO_U = {{(UW - QW + 1){1'b1}}, {(QW - 1){1'b0}}};
    localparam logic [DW-1:0] QPOS_D = {{(DW - QW + 1){1'b0}}, {(QW - 1){1'b1}}};
    localparam logic [DW-1:0] QNEG_D = {{(DW - QW){1'b0}}, 1'b1, {(QW - 1){1'b0}}};
    localparam logic [QW-1:0] QHI = {1'b0, {(QW - 1){1'b1}}};
    localparam logic [QW-1:0] QLO = {1'b1, {(QW - 1){1'b0}}};

    // Configuration registers
    logic [SW-1:0]                  r_size;
    logic [jets_pkg::C_W-1:0]       r_cre;
    logic [jets_pkg::C_W-1:0]       r_cim;
    logic [IW-1:0]                  r_iter;

    // Sequencer and datapath registers
    jets_pkg::t_state               r_state, n_state;
    logic [jets_pkg::POS_W-1:0]     r_col, n_col;
    logic [jets_pkg::POS_W-1:0]     r_row, n_row;
    logic [SW-1:0]                  r_s, n_s;
    logic [QW-1:0]                  r_x, n_x;
    logic [QW-1:0]                  r_y, n_y;
    logic [IW-1:0]                  r_k, n_k;
    logic [MW-1:0]                  r_xx, n_xx;
    logic [MW-1:0]                  r_yy, n_yy;
    logic [MW-1:0]                  r_p, n_p;
    logic signed [MW:0]             r_diff, n_diff;
    logic [jets_pkg::SHADE_W-1:0]   r_last, n_last;
    logic                           r_out_valid, n_out_valid;
    logic [jets_pkg::POS_W-1:0]     r_out_col, n_out_col;
    logic [jets_pkg::POS_W-1:0]     r_out_row, n_out_row;
    logic [jets_pkg::SHADE_W-1:0]   r_out_shade, n_out_shade;

    // Divider hookup
    logic                           div_start;
    logic [DW-1:0]                  div_dividend;
    logic [IW-1:0]                  div_divisor;
    logic                           div_done;
    logic [DW-1:0]                  div_quot;

    // Shared multiplier
    logic [QW-1:0]                  mul_a, mul_b;
    logic [MW-1:0]                  mul_p;

    // Working values
    logic [SW-1:0]                  s_clamp;
    logic [jets_pkg::NUM_W-1:0]     num_col;
    logic [jets_pkg::NUM_W-1:0]     num_row;
    logic [QW-1:0]                  ax, ay;
    logic [MW:0]                    sq_sum;
    logic signed [MW:0]             d_sh;
    logic signed [UW-1:0]           x_sum;
    logic [MW:0]                    p2;
    logic                           p_rnd;
    logic                           p_neg;
    logic [UW-1:0]                  q_mag;
    logic signed [UW-1:0]           y_sum;
    logic [jets_pkg::SPROD_W-1:0]   shade_num;
    logic                           in_acc;
    logic                           out_free;

    // Saturate a sum to the Q4 range
    function automatic logic [QW-1:0] sat_q(input logic signed [UW-1:0] v);
        logic [QW-1:0] res;
        if (v > QHI_U) begin
            res = QHI;
        end else if (v < QLO_U) begin
            res = QLO;
        end else begin
            res = v[QW-1:0];
        end
        return res;
    endfunction

    // Signed, saturated start coordinate from the quotient magnitude
    function automatic logic [QW-1:0] start_sat(input logic [DW-1:0] q, input logic neg);
        logic [QW-1:0] res;
        if (neg) begin
            res = (q > QNEG_D) ? QLO : (~q[QW-1:0] + QW'(1));
        end else begin
            res = (q > QPOS_D) ? QHI : q[QW-1:0];
        end
        return res;
    endfunction

    // Numerator 2*S - 4*pos in two's complement
    function automatic logic [jets_pkg::NUM_W-1:0] coord_num(
        input logic [SW-1:0] s,
        input logic [jets_pkg::POS_W-1:0] pos
    );
        return {1'b0, s, 1'b0} - {1'b0, pos, 2'b00};
    endfunction

    function automatic logic [DW-1:0] coord_dividend(input logic [jets_pkg::NUM_W-1:0] num);
        logic [jets_pkg::NUM_W-1:0] m;
        m = num[jets_pkg::NUM_W-1] ? (~num + jets_pkg::NUM_W'(1)) : num;
        return {m[jets_pkg::MAG_W-1:0], {FRAC_BITS{1'b0}}};
    endfunction

    jets_div #(
        .DW (DW),
        .VW (IW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign mul_p = MW'(mul_a) * MW'(mul_b);

    assign o_in_ready  = (r_state == jets_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Clamp the image size to 1..MAX_IMAGE_SIZE
    always_comb begin
        if (r_size == '0) begin
            s_clamp = SW'(1);
        end else if (32'(r_size) > 32'(MAX_IMAGE_SIZE)) begin
            s_clamp = SW'(MAX_IMAGE_SIZE);
        end else begin
            s_clamp = r_size;
        end
    end

    // Coordinate numerators, magnitudes, escape sum and update terms
    always_comb begin
        num_col = coord_num(r_s, r_col);
        num_row = coord_num(r_s, r_row);
        ax     = r_x[QW-1] ? (~r_x + QW'(1)) : r_x;
        ay     = r_y[QW-1] ? (~r_y + QW'(1)) : r_y;
        sq_sum = {1'b0, r_xx} + {1'b0, r_yy};
        d_sh   = r_diff >>> FRAC_BITS;
        x_sum  = UW'(d_sh) + UW'($signed(r_cre));
        p2     = {r_p, 1'b0};
        p_rnd  = |p2[FRAC_BITS-1:0];
        p_neg  = r_x[QW-1] ^ r_y[QW-1];
        q_mag  = UW'(p2[MW:FRAC_BITS]) + UW'(p_neg & p_rnd);
        y_sum  = (p_neg ? -$signed(q_mag) : $signed(q_mag)) + UW'($signed(r_cim));
        shade_num = jets_pkg::SPROD_W'(r_k) * jets_pkg::SPROD_W'(jets_pkg::SHADE_SCALE);
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_s         = r_s;
        n_x         = r_x;
        n_y         = r_y;
        n_k         = r_k;
        n_xx        = r_xx;
        n_yy        = r_yy;
        n_p         = r_p;
        n_diff      = r_diff;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_out_shade = r_out_shade;
        div_start    = 1'b0;
        div_dividend = coord_dividend(num_col);
        div_divisor  = IW'(r_s);
        mul_a        = ax;
        mul_b        = ax;

        // Drop the output transaction once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            jets_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_col   = i_pixel_col;
                    n_row   = i_pixel_row;
                    n_s     = s_clamp;
                    n_k     = '0;
                    n_state = jets_pkg::ST_DIV_COL;
                end
            end
            jets_pkg::ST_DIV_COL: begin
                div_start = 1'b1;
                n_state   = jets_pkg::ST_WAIT_COL;
            end
            jets_pkg::ST_WAIT_COL: begin
                if (div_done) begin
                    n_x     = start_sat(div_quot, num_col[jets_pkg::NUM_W-1]);
                    n_state = jets_pkg::ST_DIV_ROW;
                end
            end
            jets_pkg::ST_DIV_ROW: begin
                div_start    = 1'b1;
                div_dividend = coord_dividend(num_row);
                n_state      = jets_pkg::ST_WAIT_ROW;
            end
            jets_pkg::ST_WAIT_ROW: begin
                if (div_done) begin
                    n_y     = start_sat(div_quot, num_row[jets_pkg::NUM_W-1]);
                    n_state = jets_pkg::ST_SQX;
                end
            end
            // Check the step limit, then square x
            jets_pkg::ST_SQX: begin
                if (({1'b0, r_k} + (IW + 1)'(1)) < {1'b0, r_iter}) begin
                    n_xx    = mul_p;
                    n_state = jets_pkg::ST_SQY;
                end else begin
                    n_state = (r_k == '0) ? jets_pkg::ST_EMIT : jets_pkg::ST_SHADE_DIV;
                end
            end
            jets_pkg::ST_SQY: begin
                mul_a   = ay;
                mul_b   = ay;
                n_yy    = mul_p;
                n_state = jets_pkg::ST_CROSS;
            end
            // Escape test; form x*y and x^2 - y^2
            jets_pkg::ST_CROSS: begin
                mul_a = ax;
                mul_b = ay;
                if (sq_sum > FOUR) begin
                    n_state = (r_k == '0) ? jets_pkg::ST_EMIT : jets_pkg::ST_SHADE_DIV;
                end else begin
                    n_p     = mul_p;
                    n_diff  = $signed({1'b0, r_xx}) - $signed({1'b0, r_yy});
                    n_state = jets_pkg::ST_UPD;
                end
            end
            // Scale back, add c, saturate
            jets_pkg::ST_UPD: begin
                n_x     = sat_q(x_sum);
                n_y     = sat_q(y_sum);
                n_k     = r_k + IW'(1);
                n_state = jets_pkg::ST_SQX;
            end
            jets_pkg::ST_SHADE_DIV: begin
                div_start    = 1'b1;
                div_dividend = DW'(shade_num);
                div_divisor  = r_iter;
                n_state      = jets_pkg::ST_SHADE_WAIT;
            end
            jets_pkg::ST_SHADE_WAIT: begin
                if (div_done) begin
                    n_last  = div_quot[jets_pkg::SHADE_W-1:0];
                    n_state = jets_pkg::ST_EMIT;
                end
            end
            // Hand the result to the output register when it is free
            jets_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_col   = r_col;
                    n_out_row   = r_row;
                    n_out_shade = r_last;
                    n_state     = jets_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = jets_pkg::ST_IDLE;
            end
        endcase
    end

    // Registers; control and configuration reset, payload does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= jets_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_size      <= jets_pkg::RST_IMAGE_SIZE;
            r_cre       <= '0;
            r_cim       <= '0;
            r_iter      <= jets_pkg::RST_MAX_ITER;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
            if (i_cfg_valid && o_cfg_ready) begin
                case (jets_pkg::t_cfg_reg'(i_cfg_index))
                    jets_pkg::REG_IMAGE_SIZE: r_size <= i_cfg_data[SW-1:0];
                    jets_pkg::REG_C_RE:       r_cre  <= i_cfg_data[jets_pkg::C_W-1:0];
                    jets_pkg::REG_C_IM:       r_cim  <= i_cfg_data[jets_pkg::C_W-1:0];
                    jets_pkg::REG_MAX_ITER:   r_iter <= i_cfg_data[IW-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_col       <= n_col;
        r_row       <= n_row;
        r_s         <= n_s;
        r_x         <= n_x;
        r_y         <= n_y;
        r_k         <= n_k;
        r_xx        <= n_xx;
        r_yy        <= n_yy;
        r_p         <= n_p;
        r_diff      <= n_diff;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
        r_out_shade <= n_out_shade;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_col   = r_out_col;
    assign o_out_row   = r_out_row;
    assign o_shade     = r_out_shade;

endmodule
